[hw/rtl/obct_pkg.sv]
// Shared types and constants for the one-button countdown timer.
`default_nettype none

package obct_pkg;

    typedef enum logic [2:0] {
        ST_HOUR   = 3'd0,
        ST_MINUTE = 3'd1,
        ST_SECOND = 3'd2,
        ST_ACTIVE = 3'd3,
        ST_PAUSED = 3'd4,
        ST_ALERT  = 3'd5
    } t_phase;

    localparam logic [1:0] MODE_RELEASE = 2'd0;
    localparam logic [1:0] MODE_UPDATE  = 2'd1;
    localparam logic [1:0] MODE_SCENE   = 2'd2;

    localparam logic CFG_LONG   = 1'b0;
    localparam logic CFG_MEDIUM = 1'b1;

    localparam logic [15:0] LONG_RESET   = 16'd700;
    localparam logic [15:0] MEDIUM_RESET = 16'd300;

    localparam logic [5:0]  HOUR_MAX   = 6'd23;
    localparam logic [5:0]  MINSEC_MAX = 6'd59;
    localparam logic [16:0] ACC_MAX    = 17'd131071;
    localparam logic [39:0] TARGET_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [16:0] REMAIN_MAX = 17'd86399;
    localparam logic [9:0]  BLINK_MS   = 10'd500;

    localparam logic [17:0] SEC_PER_HOUR = 18'd3600;
    localparam logic [17:0] SEC_PER_MIN  = 18'd60;

    // floor(d/3600) = (d * RECIP_HOUR) >> 28 and floor(d/60) = (d * RECIP_MIN) >> 23
    // for every d up to REMAIN_MAX
    localparam logic [16:0] RECIP_HOUR = 17'd74566;
    localparam logic [17:0] RECIP_MIN  = 18'd139811;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] press_ms;
        logic [31:0] now;
        logic [9:0]  ms_phase;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic [5:0]  set_value;
        logic        has_remain;
        logic [39:0] target;
        logic [31:0] base;
        logic        blink;
    } t_snap;

endpackage

`default_nettype wire

[hw/rtl/one_button_countdown_timer.sv]
// Top level of the one-button countdown timer.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------------------
//  input    | i_in_valid / o_in_stall      | i_mode, i_press_ms, i_now_seconds, i_ms_phase
//  result   | o_out_valid / i_out_stall    | o_timer_mode, o_setting_value, o_remain_*,
//           |                              | o_blink_on
//  config   | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One item per cycle while the result is not stalled; each result passes through input
// register, state update, remaining-time difference, reciprocal multiply and split.
// Synchronous reset enters hour setting with thresholds 700 ms and 300 ms.
// o_in_stall rises only when every stage holds an item and the result is stalled.
`default_nettype none

module one_button_countdown_timer
    import obct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_press_ms,
    input  wire logic [31:0] i_now_seconds,
    input  wire logic [9:0]  i_ms_phase,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_timer_mode,
    output logic [5:0]       o_setting_value,
    output logic [4:0]       o_remain_hours,
    output logic [5:0]       o_remain_minutes,
    output logic [5:0]       o_remain_seconds,
    output logic             o_blink_on
);

    logic  snap_valid;
    logic  snap_take;
    t_snap snap;

    obct_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_press_ms    (i_press_ms),
        .i_now_seconds (i_now_seconds),
        .i_ms_phase    (i_ms_phase),
        .i_snap_take   (snap_take),
        .o_snap_valid  (snap_valid),
        .o_snap        (snap)
    );

    obct_remain u_remain (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap_valid     (snap_valid),
        .i_snap           (snap),
        .o_snap_take      (snap_take),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_timer_mode     (o_timer_mode),
        .o_setting_value  (o_setting_value),
        .o_remain_hours   (o_remain_hours),
        .o_remain_minutes (o_remain_minutes),
        .o_remain_seconds (o_remain_seconds),
        .o_blink_on       (o_blink_on)
    );

endmodule

`default_nettype wire

[hw/rtl/obct_ctrl.sv]
// Input register, configuration thresholds and timer state update.
`default_nettype none

module obct_ctrl
    import obct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_press_ms,
    input  wire logic [31:0] i_now_seconds,
    input  wire logic [9:0]  i_ms_phase,
    input  wire logic        i_snap_take,
    output logic             o_snap_valid,
    output t_snap            o_snap
);

    logic [15:0] r_long;
    logic [15:0] r_medium;
    logic        r_v1;
    t_item       r_item;
    logic        r_v2;
    t_snap       r_snap;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_set, n_set;
    logic [16:0] r_acc, n_acc;
    logic [39:0] r_target, n_target;
    logic [31:0] r_pause, n_pause;

    logic        ld1, ld2, step;
    logic        is_long, is_med, go_hour;
    logic [5:0]  maxv;
    logic [17:0] prod;
    logic [18:0] sum;
    logic [16:0] acc_sat;
    logic [6:0]  up_v;
    logic [5:0]  up_res, dn_v, dn_res;
    logic [41:0] resume_t;
    logic [39:0] resume_sat;
    logic [39:0] start_target;
    t_snap       n_snap;

    assign ld2        = !r_v2 || i_snap_take;
    assign ld1        = !r_v1 || ld2;
    assign step       = r_v1 && ld2;
    assign o_in_stall = !ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long   <= LONG_RESET;
            r_medium <= MEDIUM_RESET;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_phase  <= ST_HOUR;
            r_set    <= '0;
            r_acc    <= '0;
            r_target <= '0;
            r_pause  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LONG:   r_long   <= i_cfg_data;
                    CFG_MEDIUM: r_medium <= i_cfg_data;
                    default:    r_long   <= r_long;
                endcase
            end
            if (ld1) begin
                r_v1 <= i_in_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            r_phase  <= n_phase;
            r_set    <= n_set;
            r_acc    <= n_acc;
            r_target <= n_target;
            r_pause  <= n_pause;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1 && i_in_valid) begin
            r_item <= '{mode: i_mode, press_ms: i_press_ms, now: i_now_seconds,
                        ms_phase: i_ms_phase};
        end
        if (step) begin
            r_snap <= n_snap;
        end
    end

    always_comb begin
        is_long = r_item.press_ms > r_long;
        is_med  = r_item.press_ms > r_medium;
        maxv    = (r_phase == ST_HOUR) ? HOUR_MAX : MINSEC_MAX;

        unique case (r_phase)
            ST_HOUR:   prod = 18'(r_set) * SEC_PER_HOUR;
            ST_MINUTE: prod = 18'(r_set) * SEC_PER_MIN;
            default:   prod = 18'(r_set);
        endcase
        sum     = 19'(r_acc) + 19'(prod);
        acc_sat = (sum > 19'(ACC_MAX)) ? ACC_MAX : sum[16:0];

        up_v   = 7'(r_set) + 7'd1;
        up_res = (up_v > 7'(maxv)) ? 6'd0 : up_v[5:0];
        dn_v   = r_set - 6'd1;
        dn_res = (r_set == 6'd0) ? maxv : ((dn_v > maxv) ? 6'd0 : dn_v);

        resume_t   = 42'(r_target) + 42'(r_item.now) - 42'(r_pause);
        resume_sat = resume_t[41] ? 40'd0 : (resume_t[40] ? TARGET_MAX : resume_t[39:0]);

        start_target = 40'(r_item.now) + 40'(acc_sat);

        n_phase  = r_phase;
        n_set    = r_set;
        n_acc    = r_acc;
        n_target = r_target;
        n_pause  = r_pause;
        go_hour  = 1'b0;

        if (step) begin
            unique case (r_item.mode)
                MODE_RELEASE: begin
                    unique case (r_phase)
                        ST_HOUR, ST_MINUTE, ST_SECOND: begin
                            priority if (is_long) begin
                                n_acc = acc_sat;
                                n_set = 6'd0;
                                unique case (r_phase)
                                    ST_HOUR:   n_phase = ST_MINUTE;
                                    ST_MINUTE: n_phase = ST_SECOND;
                                    default: begin
                                        n_phase  = ST_ACTIVE;
                                        n_target = start_target;
                                    end
                                endcase
                            end else if (is_med) begin
                                n_set = dn_res;
                            end else begin
                                n_set = up_res;
                            end
                        end
                        ST_ACTIVE: begin
                            if (is_long) begin
                                go_hour = 1'b1;
                            end else begin
                                n_pause = r_item.now;
                                n_phase = ST_PAUSED;
                            end
                        end
                        ST_PAUSED: begin
                            n_target = resume_sat;
                            n_phase  = ST_ACTIVE;
                        end
                        ST_ALERT: begin
                            go_hour = 1'b1;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                MODE_UPDATE: begin
                    if (r_phase == ST_ACTIVE && r_target <= 40'(r_item.now)) begin
                        n_phase = ST_ALERT;
                    end
                end
                MODE_SCENE: begin
                    if (r_phase != ST_ACTIVE && r_phase != ST_PAUSED) begin
                        go_hour = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (go_hour) begin
            n_phase  = ST_HOUR;
            n_set    = 6'd0;
            n_acc    = 17'd0;
            n_target = 40'd0;
        end

        n_snap.phase      = n_phase;
        n_snap.set_value  = n_set;
        n_snap.has_remain = (n_phase == ST_ACTIVE) || (n_phase == ST_PAUSED);
        n_snap.target     = n_target;
        n_snap.base       = (n_phase == ST_ACTIVE) ? r_item.now : n_pause;
        n_snap.blink      = r_item.ms_phase >= BLINK_MS;
    end

    assign o_snap_valid = r_v2;
    assign o_snap       = r_snap;

    a_alert_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_item.mode == MODE_RELEASE && r_phase == ST_ALERT
        |=> r_phase == ST_HOUR && r_acc == 17'd0 && r_target == 40'd0)
        else $error("release while alerting did not restart hour setting");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_phase) && $stable(r_set) && $stable(r_acc) && $stable(r_target))
        else $error("timer state changed without a transfer");

    a_update_only_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_item.mode == MODE_UPDATE && r_phase != ST_ACTIVE
        |=> r_phase == $past(r_phase))
        else $error("update changed phase outside the active state");

endmodule

`default_nettype wire

[hw/rtl/obct_remain.sv]
// Remaining-time saturation, split into hours, minutes, seconds, and result register.
`default_nettype none

module obct_remain
    import obct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_snap_valid,
    input  wire t_snap      i_snap,
    output logic            o_snap_take,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_timer_mode,
    output logic [5:0]      o_setting_value,
    output logic [4:0]      o_remain_hours,
    output logic [5:0]      o_remain_minutes,
    output logic [5:0]      o_remain_seconds,
    output logic            o_blink_on
);

    typedef struct packed {
        t_phase     phase;
        logic [5:0] set_value;
        logic       blink;
    } t_show;

    logic        r_v3, r_v4, r_vo;
    logic [16:0] r_d3, r_d4;
    t_show       r_show3, r_show4, r_show_o;
    logic [4:0]  r_h4, r_hours;
    logic [10:0] r_tm4;
    logic [5:0]  r_minutes, r_seconds;

    logic        rdy_out, rdy4, rdy3;
    logic [40:0] diff;
    logic [16:0] d_sat;
    logic [33:0] hour_prod;
    logic [34:0] min_prod;
    logic [10:0] mins;
    logic [16:0] secs;

    assign rdy_out     = !r_vo || !i_out_stall;
    assign rdy4        = !r_v4 || rdy_out;
    assign rdy3        = !r_v3 || rdy4;
    assign o_snap_take = rdy3;

    always_comb begin
        diff = {1'b0, i_snap.target} - {9'd0, i_snap.base};
        if (!i_snap.has_remain || diff[40]) begin
            d_sat = 17'd0;
        end else if (diff[39:0] > 40'(REMAIN_MAX)) begin
            d_sat = REMAIN_MAX;
        end else begin
            d_sat = diff[16:0];
        end
        hour_prod = 34'(r_d3) * 34'(RECIP_HOUR);
        min_prod  = 35'(r_d3) * 35'(RECIP_MIN);
        mins      = r_tm4 - 11'(r_h4) * 11'(SEC_PER_MIN);
        secs      = r_d4 - 17'(r_tm4) * 17'(SEC_PER_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy3) begin
                r_v3 <= i_snap_valid;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy_out) begin
                r_vo <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && i_snap_valid) begin
            r_d3    <= d_sat;
            r_show3 <= '{phase: i_snap.phase, set_value: i_snap.set_value,
                         blink: i_snap.blink};
        end
        if (rdy4 && r_v3) begin
            r_d4    <= r_d3;
            r_h4    <= hour_prod[32:28];
            r_tm4   <= min_prod[33:23];
            r_show4 <= r_show3;
        end
        if (rdy_out && r_v4) begin
            r_hours   <= r_h4;
            r_minutes <= mins[5:0];
            r_seconds <= secs[5:0];
            r_show_o  <= r_show4;
        end
    end

    assign o_out_valid      = r_vo;
    assign o_timer_mode     = r_show_o.phase;
    assign o_setting_value  = r_show_o.set_value;
    assign o_remain_hours   = r_hours;
    assign o_remain_minutes = r_minutes;
    assign o_remain_seconds = r_seconds;
    assign o_blink_on       = r_show_o.blink;

    a_hour_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (17'(r_h4) * 17'd3600 <= r_d4) && (r_d4 < 17'(r_h4) * 17'd3600 + 17'd3600))
        else $error("hour quotient out of range");

    a_minute_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (17'(r_tm4) * 17'd60 <= r_d4) && (r_d4 < 17'(r_tm4) * 17'd60 + 17'd60))
        else $error("minute quotient out of range");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> r_hours < 5'd24 && r_minutes < 6'd60 && r_seconds < 6'd60)
        else $error("remaining time field out of range");

endmodule

`default_nettype wire
